/* rtl/core/epq_pkg.sv */
`timescale 1ns / 1ps

package epq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_ZERO_PID  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic KIND_ARRIVAL   = 1'b0;
  localparam logic KIND_TERMINATE = 1'b1;

  typedef struct packed {
    logic [31:0] ev_time;
    logic        ev_kind;
    logic [31:0] ev_pid;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins_en;
    logic occupied;
    logic at_tail;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/core/event_priority_queue_insert.sv */
`timescale 1ns / 1ps
// Sorted event store built as a row of QUEUE_DEPTH cells. Each transfer offers one
// event; it is placed behind every stored event with an earlier time, terminates
// ahead of arrivals at equal time, equal events in arrival order. Every cell
// compares its own entry with the new event in parallel and either keeps it, takes
// its left neighbour's entry or loads the new event, so one event can be accepted
// every cycle. The result (status, head event and count after the insert)
// appears in the output register the cycle after the transfer; input is stalled
// only while that register holds a result that is itself stalled. Zero process
// ids and inserts into a full store leave the store unchanged.
module event_priority_queue_insert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] event_time_i,
  input  logic        event_kind_i,
  input  logic [31:0] process_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] head_time_o,
  output logic        head_kind_o,
  output logic [31:0] head_process_o,
  output logic [4:0]  entry_count_o
);
  import epq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  entry_t           head_q, head_d;

  logic             accept;
  logic             ok_insert;
  entry_t           new_entry;
  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_before [QUEUE_DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign new_entry  = '{ev_time: event_time_i, ev_kind: event_kind_i, ev_pid: process_id_i};

  assign ok_insert  = accept && (process_id_i != '0) &&
                      (count_q < CNT_W'(QUEUE_DEPTH));

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     left_entry;

    assign ctrl.ins_en   = ok_insert;
    assign ctrl.occupied = CNT_W'(i) < count_q;
    assign ctrl.at_tail  = CNT_W'(i) == count_q;
    if (i == 0) begin : g_first
      assign ctrl.shift = 1'b0;
      assign left_entry = '0;
    end else begin : g_rest
      // once the new event lands to the left, everything from here moves up
      assign ctrl.shift = cell_before[i-1];
      assign left_entry = cell_entry[i-1];
    end

    epq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .left_entry_i (left_entry),
      .new_entry_i  (new_entry),
      .before_o     (cell_before[i]),
      .entry_o      (cell_entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    head_d   = '0;
    if (process_id_i == '0) begin
      status_d = ST_ZERO_PID;
    end else if (!ok_insert) begin
      status_d = ST_FULL;
    end
    if (ok_insert) begin
      count_d = count_q + CNT_W'(1);
      if (cell_before[0] || (count_q == '0)) begin
        head_d = new_entry;
      end else begin
        head_d = cell_entry[0];
      end
    end else if (count_q != '0) begin
      head_d = cell_entry[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign head_time_o    = head_q.ev_time;
  assign head_kind_o    = head_q.ev_kind;
  assign head_process_o = head_q.ev_pid;
  assign entry_count_o  = COUNT_OUT_W'(count_q);

endmodule

/* rtl/core/epq_cell.sv */
`timescale 1ns / 1ps

module epq_cell (
  input  logic               clk_i,
  input  epq_pkg::cell_ctrl_t ctrl_i,
  input  epq_pkg::entry_t    left_entry_i,
  input  epq_pkg::entry_t    new_entry_i,
  output logic               before_o,
  output epq_pkg::entry_t    entry_o
);
  import epq_pkg::*;

  entry_t slot_q;
  entry_t slot_d;
  logic   later_time;
  logic   term_over_arr;

  // new event goes ahead of this slot on a later stored time, or on equal time
  // when a terminate meets a stored arrival
  assign later_time    = slot_q.ev_time > new_entry_i.ev_time;
  assign term_over_arr = (slot_q.ev_time == new_entry_i.ev_time) &&
                         (new_entry_i.ev_kind == KIND_TERMINATE) &&
                         (slot_q.ev_kind == KIND_ARRIVAL);
  assign before_o      = ctrl_i.occupied && (later_time || term_over_arr);

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.ins_en) begin
      if (ctrl_i.shift) begin
        slot_d = left_entry_i;
      end else if (before_o || ctrl_i.at_tail) begin
        slot_d = new_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign entry_o = slot_q;

endmodule

/* rtl/core/epq_checker.sv */
`timescale 1ns / 1ps

module epq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] process_id_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] head_time_o,
  input logic        head_kind_o,
  input logic [31:0] head_process_o,
  input logic [4:0]  entry_count_o
);
  import epq_pkg::*;

  // a held result must not change under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(head_time_o) && $stable(head_process_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  // every transfer in gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result after input transfer");

  a_zero_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (process_id_i == '0) |=> status_o == ST_ZERO_PID)
    else $error("zero process id not rejected");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == COUNT_OUT_W'(QUEUE_DEPTH))
    else $error("full status with store not full");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_count_o == '0) |->
    (head_time_o == '0) && (head_process_o == '0) && !head_kind_o)
    else $error("empty store shows a head event");

endmodule

bind event_priority_queue_insert epq_checker u_epq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .process_id_i   (process_id_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .head_time_o    (head_time_o),
  .head_kind_o    (head_kind_o),
  .head_process_o (head_process_o),
  .entry_count_o  (entry_count_o)
);
